// ===== rtl/ccse_pkg.sv =====
// Shared constants, types and codes of the Chebyshev Clenshaw evaluator.
package ccse_pkg;

   localparam int MAX_TERMS = 1024;
   localparam int COEFF_WIDTH = 48;
   localparam int ADDR_WIDTH = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   localparam int VAL_WIDTH = 48;
   localparam int X_WIDTH = 32;
   localparam int ORDER_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int OPERAND_WIDTH = VAL_WIDTH + 1;
   localparam int MAG_WIDTH = VAL_WIDTH;
   localparam int HALF_WIDTH = MAG_WIDTH / 2;
   localparam int PROD_WIDTH = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH = VAL_WIDTH + 2;
   localparam int MUL_STEPS = 4;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   localparam logic signed [VAL_WIDTH-1:0] VAL_MAX = {1'b0, {(VAL_WIDTH-1){1'b1}}};
   localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = {1'b1, {(VAL_WIDTH-1){1'b0}}};
   localparam logic signed [VAL_WIDTH-1:0] COEFF_MAX = (COEFF_WIDTH >= VAL_WIDTH) ? VAL_MAX :
      VAL_WIDTH'((64'sd1 <<< (COEFF_WIDTH - 1)) - 64'sd1);
   localparam logic signed [VAL_WIDTH-1:0] COEFF_MIN = -COEFF_MAX - VAL_WIDTH'(1);

   // 0.5 in Q16.32.
   localparam logic signed [VAL_WIDTH-1:0] HALF_ONE = 48'sh0000_8000_0000;

   localparam logic [VAL_WIDTH-1:0] Z_SCALE_RESET = 48'h0002_0000_0000;
   localparam logic [VAL_WIDTH-1:0] Z_OFFSET_RESET = 48'h0001_0000_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TERM_ORDER = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Z_SCALE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Z_OFFSET = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [1:0] {
      SH_28,
      SH_31,
      SH_32
   } shift_type;

   typedef struct packed {
      logic start;
      logic signed [OPERAND_WIDTH-1:0] a;
      logic signed [OPERAND_WIDTH-1:0] b;
      shift_type shift;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic signed [VAL_WIDTH-1:0] value;
      logic sat;
   } mul_rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_X2,
      PH_Z,
      PH_TERM,
      PH_D,
      PH_H
   } phase_type;

endpackage

// ===== rtl/ccse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ccse_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ccse_mul.sv =====
// Iterative signed fixed-point multiplier with round-half-away and 48-bit saturation.
module ccse_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  ccse_pkg::mul_req_type req,
   output ccse_pkg::mul_rsp_type rsp
);

   logic [ccse_pkg::MAG_WIDTH-1:0]  ma_ff, ma_in;
   logic [ccse_pkg::MAG_WIDTH-1:0]  mb_ff, mb_in;
   logic                            neg_ff, neg_in;
   ccse_pkg::shift_type             shift_ff, shift_in;
   logic [ccse_pkg::PROD_WIDTH-1:0] acc_ff, acc_in;
   logic [2:0]                      step_ff, step_in;
   logic                            busy_ff, busy_in;
   ccse_pkg::mul_rsp_type           rsp_ff, rsp_in;

   logic [ccse_pkg::OPERAND_WIDTH-1:0]  a_mag, b_mag;
   logic [ccse_pkg::HALF_WIDTH-1:0]     part_a, part_b;
   logic [ccse_pkg::MAG_WIDTH-1:0]      part_prod;
   logic [1:0]                          lane;
   logic [ccse_pkg::PROD_WIDTH-1:0]     part_shifted;
   logic [6:0]                          amount;
   logic [ccse_pkg::PROD_WIDTH:0]       rnd, rounded, quotient;
   logic [ccse_pkg::MAG_WIDTH-1:0]      lim_mag, mag;
   logic                                over;
   logic signed [ccse_pkg::VAL_WIDTH-1:0] value;

   // One 24x24 partial product per step, placed by the sum of the half indexes.
   always_comb begin
      a_mag = req.a[ccse_pkg::OPERAND_WIDTH-1] ? ccse_pkg::OPERAND_WIDTH'(-req.a)
                                               : ccse_pkg::OPERAND_WIDTH'(req.a);
      b_mag = req.b[ccse_pkg::OPERAND_WIDTH-1] ? ccse_pkg::OPERAND_WIDTH'(-req.b)
                                               : ccse_pkg::OPERAND_WIDTH'(req.b);
      part_a = step_ff[1] ? ma_ff[ccse_pkg::MAG_WIDTH-1:ccse_pkg::HALF_WIDTH]
                          : ma_ff[ccse_pkg::HALF_WIDTH-1:0];
      part_b = step_ff[0] ? mb_ff[ccse_pkg::MAG_WIDTH-1:ccse_pkg::HALF_WIDTH]
                          : mb_ff[ccse_pkg::HALF_WIDTH-1:0];
      part_prod = part_a * part_b;
      lane = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      case (lane)
         2'd0:    part_shifted = ccse_pkg::PROD_WIDTH'(part_prod);
         2'd1:    part_shifted = ccse_pkg::PROD_WIDTH'(part_prod) << ccse_pkg::HALF_WIDTH;
         default: part_shifted = ccse_pkg::PROD_WIDTH'(part_prod) << (2 * ccse_pkg::HALF_WIDTH);
      endcase
   end

   // Rounding and saturation of the finished magnitude.
   always_comb begin
      case (shift_ff)
         ccse_pkg::SH_28: amount = 7'd28;
         ccse_pkg::SH_31: amount = 7'd31;
         default:         amount = 7'd32;
      endcase
      rnd = (ccse_pkg::PROD_WIDTH + 1)'(1) << (amount - 7'd1);
      rounded = {1'b0, acc_ff} + rnd;
      quotient = rounded >> amount;
      lim_mag = neg_ff ? ccse_pkg::MAG_WIDTH'(ccse_pkg::VAL_MIN)
                       : ccse_pkg::MAG_WIDTH'(ccse_pkg::VAL_MAX);
      over = quotient > (ccse_pkg::PROD_WIDTH + 1)'(lim_mag);
      mag = over ? lim_mag : quotient[ccse_pkg::MAG_WIDTH-1:0];
      value = neg_ff ? ccse_pkg::VAL_WIDTH'(-mag) : ccse_pkg::VAL_WIDTH'(mag);
   end

   always_comb begin
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      shift_in = shift_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      rsp_in = rsp_ff;
      rsp_in.done = 1'b0;
      if (!busy_ff) begin
         if (req.start) begin
            ma_in = a_mag[ccse_pkg::MAG_WIDTH-1:0];
            mb_in = b_mag[ccse_pkg::MAG_WIDTH-1:0];
            neg_in = req.a[ccse_pkg::OPERAND_WIDTH-1] ^ req.b[ccse_pkg::OPERAND_WIDTH-1];
            shift_in = req.shift;
            acc_in = '0;
            step_in = '0;
            busy_in = 1'b1;
         end
      end else if (step_ff != 3'(ccse_pkg::MUL_STEPS)) begin
         acc_in = acc_ff + part_shifted;
         step_in = step_ff + 3'd1;
      end else begin
         busy_in = 1'b0;
         rsp_in.done = 1'b1;
         rsp_in.value = value;
         rsp_in.sat = over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         rsp_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         rsp_ff <= rsp_in;
      end
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      shift_ff <= shift_in;
      acc_ff <= acc_in;
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/chebyshev_clenshaw_sign_eval.sv =====
// Top level: coefficient table, Clenshaw sequencer and the shared multiplier.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  opcode, coeff_index, coeff_value, x_value
//   rsp      out        rsp_valid/rsp_ready  h_value, saturated
//   csr      in         csr_wr_en            csr_index, csr_wr_data
//
// A load word writes one table entry; it gives no result.
// An evaluate word runs term_order + 5 multiplies on the one shared multiplier, each
// made of issue, four 24x24 partial products, rounding and combine; rsp_valid
// rises once the last combine is done and the output register is free.
// The block takes no new word while an evaluation runs. Loads are still taken while
// a result waits; a finished evaluation holds until the output register is free.
// Reset restores the state, the configuration registers and rsp_valid; the coefficient table is not cleared.
module chebyshev_clenshaw_sign_eval (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic                                       req_opcode,
   input  logic [ccse_pkg::ORDER_WIDTH-1:0]           req_coeff_index,
   input  logic signed [ccse_pkg::VAL_WIDTH-1:0]      req_coeff_value,
   input  logic signed [ccse_pkg::X_WIDTH-1:0]        req_x_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [ccse_pkg::VAL_WIDTH-1:0]      rsp_h_value,
   output logic                                       rsp_saturated,
   input  logic                                       csr_wr_en,
   input  logic [ccse_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [ccse_pkg::VAL_WIDTH-1:0]             csr_wr_data
);

   ccse_pkg::state_type state_ff, state_in;
   ccse_pkg::phase_type phase_ff, phase_in;

   logic [ccse_pkg::ORDER_WIDTH-1:0]       term_order_ff, term_order_in;
   logic [ccse_pkg::VAL_WIDTH-1:0]         z_scale_ff, z_scale_in;
   logic [ccse_pkg::VAL_WIDTH-1:0]         z_offset_ff, z_offset_in;

   logic signed [ccse_pkg::X_WIDTH-1:0]    x_ff, x_in;
   logic signed [ccse_pkg::VAL_WIDTH-1:0]  z_ff, z_in;
   logic signed [ccse_pkg::VAL_WIDTH-1:0]  b0_ff, b0_in;
   logic signed [ccse_pkg::VAL_WIDTH-1:0]  b1_ff, b1_in;
   ccse_pkg::addr_type                     n_ff, n_in;
   logic                                   sat_ff, sat_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [ccse_pkg::VAL_WIDTH-1:0]  rsp_h_value_ff, rsp_h_value_in;
   logic                                   rsp_saturated_ff, rsp_saturated_in;

   ccse_pkg::mul_req_type                  mul_req;
   ccse_pkg::mul_rsp_type                  mul_rsp;

   logic                                   ram_wr_en, ram_rd_en;
   ccse_pkg::addr_type                     ram_wr_addr, ram_rd_addr;
   logic [ccse_pkg::VAL_WIDTH-1:0]         ram_wr_data, ram_rd_data;

   logic                                   req_fire, eval_accept, load_accept, index_ok;
   logic                                   out_free;
   ccse_pkg::addr_type                     order_eff;
   logic signed [ccse_pkg::SUM_WIDTH-1:0]  combine_sum;
   logic [ccse_pkg::VAL_WIDTH:0]           combine_clamped;

   // Returns {saturated, value} for a wide sum clamped to the signed 48-bit range.
   function automatic logic [ccse_pkg::VAL_WIDTH:0] clamp_val(
      input logic signed [ccse_pkg::SUM_WIDTH-1:0] v
   );
      logic [ccse_pkg::VAL_WIDTH:0] r;
      if (v > ccse_pkg::SUM_WIDTH'(ccse_pkg::VAL_MAX)) begin
         r = {1'b1, ccse_pkg::VAL_MAX};
      end else if (v < ccse_pkg::SUM_WIDTH'(ccse_pkg::VAL_MIN)) begin
         r = {1'b1, ccse_pkg::VAL_MIN};
      end else begin
         r = {1'b0, v[ccse_pkg::VAL_WIDTH-1:0]};
      end
      return r;
   endfunction

   function automatic logic [ccse_pkg::VAL_WIDTH-1:0] sat_coeff(
      input logic signed [ccse_pkg::VAL_WIDTH-1:0] v
   );
      logic [ccse_pkg::VAL_WIDTH-1:0] r;
      if (v > ccse_pkg::COEFF_MAX) begin
         r = ccse_pkg::COEFF_MAX;
      end else if (v < ccse_pkg::COEFF_MIN) begin
         r = ccse_pkg::COEFF_MIN;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign req_fire = req_valid && req_ready;
   assign eval_accept = req_fire && (req_opcode == ccse_pkg::OP_EVAL);
   assign load_accept = req_fire && (req_opcode == ccse_pkg::OP_LOAD);
   assign index_ok = 32'(req_coeff_index) < ccse_pkg::MAX_TERMS;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign order_eff = (32'(term_order_ff) >= ccse_pkg::MAX_TERMS) ?
                      ccse_pkg::addr_type'(ccse_pkg::MAX_TERMS - 1) :
                      ccse_pkg::addr_type'(term_order_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ccse_pkg::S_IDLE: begin
            if (eval_accept) begin
               state_in = ccse_pkg::S_ISSUE;
               phase_in = ccse_pkg::PH_X2;
            end
         end
         ccse_pkg::S_ISSUE: begin
            state_in = ccse_pkg::S_WAIT;
         end
         ccse_pkg::S_WAIT: begin
            if (mul_rsp.done) begin
               state_in = ccse_pkg::S_ISSUE;
               unique case (phase_ff)
                  ccse_pkg::PH_X2:   phase_in = ccse_pkg::PH_Z;
                  ccse_pkg::PH_Z:    phase_in = ccse_pkg::PH_TERM;
                  ccse_pkg::PH_TERM: begin
                     if (n_ff == '0) begin
                        phase_in = ccse_pkg::PH_D;
                     end
                  end
                  ccse_pkg::PH_D:    phase_in = ccse_pkg::PH_H;
                  ccse_pkg::PH_H:    state_in = ccse_pkg::S_DONE;
                  default:           phase_in = ccse_pkg::PH_X2;
               endcase
            end
         end
         ccse_pkg::S_DONE: begin
            if (out_free) begin
               state_in = ccse_pkg::S_IDLE;
            end
         end
         default: state_in = ccse_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, multiplier operands and table access.
   always_comb begin
      req_ready = (state_ff == ccse_pkg::S_IDLE);
      ram_wr_en = load_accept && index_ok;
      ram_wr_addr = ccse_pkg::addr_type'(req_coeff_index);
      ram_wr_data = sat_coeff(req_coeff_value);
      ram_rd_en = 1'b0;
      ram_rd_addr = n_ff;
      mul_req.start = (state_ff == ccse_pkg::S_ISSUE);
      mul_req.a = ccse_pkg::OPERAND_WIDTH'(x_ff);
      mul_req.b = ccse_pkg::OPERAND_WIDTH'(x_ff);
      mul_req.shift = ccse_pkg::SH_28;
      unique case (phase_ff)
         ccse_pkg::PH_X2: begin
            mul_req.shift = ccse_pkg::SH_28;
         end
         ccse_pkg::PH_Z: begin
            mul_req.a = signed'({1'b0, z_scale_ff});
            mul_req.b = ccse_pkg::OPERAND_WIDTH'(z_ff);
            mul_req.shift = ccse_pkg::SH_32;
         end
         ccse_pkg::PH_TERM: begin
            // The coefficient is read while the multiplier works and is held until use.
            ram_rd_en = (state_ff == ccse_pkg::S_ISSUE);
            mul_req.a = ccse_pkg::OPERAND_WIDTH'(z_ff);
            mul_req.b = ccse_pkg::OPERAND_WIDTH'(b0_ff);
            mul_req.shift = ccse_pkg::SH_31;
         end
         ccse_pkg::PH_D: begin
            mul_req.a = ccse_pkg::OPERAND_WIDTH'(b1_ff);
            mul_req.b = ccse_pkg::OPERAND_WIDTH'(z_ff);
            mul_req.shift = ccse_pkg::SH_32;
         end
         ccse_pkg::PH_H: begin
            mul_req.b = ccse_pkg::OPERAND_WIDTH'(b0_ff);
            mul_req.shift = ccse_pkg::SH_31;
         end
         default: begin
            mul_req.shift = ccse_pkg::SH_28;
         end
      endcase
   end

   // The add that follows each multiply, chosen by phase.
   always_comb begin
      unique case (phase_ff)
         ccse_pkg::PH_Z:
            combine_sum = ccse_pkg::SUM_WIDTH'(mul_rsp.value) - signed'({2'b00, z_offset_ff});
         ccse_pkg::PH_TERM:
            combine_sum = ccse_pkg::SUM_WIDTH'(signed'(ram_rd_data))
                          + ccse_pkg::SUM_WIDTH'(mul_rsp.value) - ccse_pkg::SUM_WIDTH'(b1_ff);
         ccse_pkg::PH_D:
            combine_sum = ccse_pkg::SUM_WIDTH'(b0_ff) - ccse_pkg::SUM_WIDTH'(mul_rsp.value);
         ccse_pkg::PH_H:
            combine_sum = ccse_pkg::SUM_WIDTH'(ccse_pkg::HALF_ONE)
                          - ccse_pkg::SUM_WIDTH'(mul_rsp.value);
         default:
            combine_sum = ccse_pkg::SUM_WIDTH'(mul_rsp.value);
      endcase
      combine_clamped = clamp_val(combine_sum);
   end

   // Datapath and configuration registers.
   always_comb begin
      term_order_in = term_order_ff;
      z_scale_in = z_scale_ff;
      z_offset_in = z_offset_ff;
      x_in = x_ff;
      z_in = z_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      n_in = n_ff;
      sat_in = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_h_value_in = rsp_h_value_ff;
      rsp_saturated_in = rsp_saturated_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            ccse_pkg::CSR_TERM_ORDER: term_order_in = csr_wr_data[ccse_pkg::ORDER_WIDTH-1:0];
            ccse_pkg::CSR_Z_SCALE:    z_scale_in = csr_wr_data;
            ccse_pkg::CSR_Z_OFFSET:   z_offset_in = csr_wr_data;
            default:                  term_order_in = term_order_ff;
         endcase
      end

      if (eval_accept) begin
         x_in = req_x_value;
         b0_in = '0;
         b1_in = '0;
         n_in = order_eff;
         sat_in = 1'b0;
      end

      if (state_ff == ccse_pkg::S_WAIT && mul_rsp.done) begin
         sat_in = sat_ff | mul_rsp.sat;
         unique case (phase_ff)
            ccse_pkg::PH_X2: begin
               z_in = mul_rsp.value;
            end
            ccse_pkg::PH_Z: begin
               z_in = combine_clamped[ccse_pkg::VAL_WIDTH-1:0];
               sat_in = sat_ff | mul_rsp.sat | combine_clamped[ccse_pkg::VAL_WIDTH];
            end
            ccse_pkg::PH_TERM: begin
               b1_in = b0_ff;
               b0_in = combine_clamped[ccse_pkg::VAL_WIDTH-1:0];
               sat_in = sat_ff | mul_rsp.sat | combine_clamped[ccse_pkg::VAL_WIDTH];
               n_in = n_ff - ccse_pkg::addr_type'(1);
            end
            ccse_pkg::PH_D, ccse_pkg::PH_H: begin
               b0_in = combine_clamped[ccse_pkg::VAL_WIDTH-1:0];
               sat_in = sat_ff | mul_rsp.sat | combine_clamped[ccse_pkg::VAL_WIDTH];
            end
            default: begin
               z_in = z_ff;
            end
         endcase
      end

      if (state_ff == ccse_pkg::S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_h_value_in = b0_ff;
         rsp_saturated_in = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccse_pkg::S_IDLE;
         phase_ff <= ccse_pkg::PH_X2;
         term_order_ff <= '0;
         z_scale_ff <= ccse_pkg::Z_SCALE_RESET;
         z_offset_ff <= ccse_pkg::Z_OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         term_order_ff <= term_order_in;
         z_scale_ff <= z_scale_in;
         z_offset_ff <= z_offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff <= x_in;
      z_ff <= z_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      n_ff <= n_in;
      sat_ff <= sat_in;
      rsp_h_value_ff <= rsp_h_value_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   ccse_ram #(
      .WIDTH (ccse_pkg::VAL_WIDTH),
      .DEPTH (ccse_pkg::MAX_TERMS)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ccse_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_h_value = rsp_h_value_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // An accepted evaluate word always starts with the x*x multiply.
   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      eval_accept |=> (state_ff == ccse_pkg::S_ISSUE) && (phase_ff == ccse_pkg::PH_X2))
      else $error("evaluate word did not start the x*x multiply");

   // The multiplier only finishes while the sequencer is waiting for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ccse_pkg::S_WAIT))
      else $error("multiplier finished outside the wait state");

   // A new result only appears when an evaluation has just finished.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ccse_pkg::S_DONE))
      else $error("result word appeared without a finished evaluation");

endmodule

// ===== dv/chebyshev_clenshaw_sign_eval_tb.sv =====
// Self-checking testbench for the Chebyshev Clenshaw sign evaluator.
module chebyshev_clenshaw_sign_eval_tb;

   typedef struct packed {
      logic                                  opcode;
      logic [ccse_pkg::ORDER_WIDTH-1:0]      index;
      logic signed [ccse_pkg::VAL_WIDTH-1:0] coeff;
      logic signed [ccse_pkg::X_WIDTH-1:0]   x;
   } series_word_type;

   typedef struct packed {
      logic signed [ccse_pkg::VAL_WIDTH-1:0] h;
      logic                                  sat;
   } h_result_type;

   localparam logic signed [63:0] TOP48 = 64'(ccse_pkg::VAL_MAX);
   localparam logic signed [63:0] BOTTOM48 = 64'(ccse_pkg::VAL_MIN);
   localparam logic signed [63:0] HALF_Q32 = 64'(ccse_pkg::HALF_ONE);

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic                                  req_opcode = ccse_pkg::OP_LOAD;
   logic [ccse_pkg::ORDER_WIDTH-1:0]      req_coeff_index = '0;
   logic signed [ccse_pkg::VAL_WIDTH-1:0] req_coeff_value = '0;
   logic signed [ccse_pkg::X_WIDTH-1:0]   req_x_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [ccse_pkg::VAL_WIDTH-1:0] rsp_h_value;
   logic                                  rsp_saturated;
   logic                                  csr_wr_en = 1'b0;
   logic [ccse_pkg::CSR_INDEX_WIDTH-1:0]  csr_index = ccse_pkg::CSR_TERM_ORDER;
   logic [ccse_pkg::VAL_WIDTH-1:0]        csr_wr_data = '0;

   // Predictor state: its own copy of the coefficients and registers.
   logic signed [ccse_pkg::VAL_WIDTH-1:0] coeff_copy [ccse_pkg::MAX_TERMS];
   logic [ccse_pkg::ORDER_WIDTH-1:0]      order_cfg = '0;
   logic [ccse_pkg::VAL_WIDTH-1:0]        scale_cfg = ccse_pkg::Z_SCALE_RESET;
   logic [ccse_pkg::VAL_WIDTH-1:0]        offset_cfg = ccse_pkg::Z_OFFSET_RESET;

   series_word_type word_queue[$];
   series_word_type cur_word;
   h_result_type    h_pending[$];
   int              words_left = 0;
   int              mismatches = 0;
   int              gap_left = 0;
   int              burst_left = 0;
   logic            no_idle = 1'b0;
   logic [15:0]     stall_pattern = 16'hFFFF;

   chebyshev_clenshaw_sign_eval dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_x_value     (req_x_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_h_value     (rsp_h_value),
      .rsp_saturated   (rsp_saturated),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic signed [63:0] clamp48(input logic signed [63:0] v, inout bit sat);
      if (v > TOP48) begin
         sat = 1'b1;
         return TOP48;
      end
      if (v < BOTTOM48) begin
         sat = 1'b1;
         return BOTTOM48;
      end
      return v;
   endfunction

   // Product shifted right by sh, rounded half away from zero, saturated to 48 bits.
   function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input int unsigned sh, inout bit sat);
      logic [63:0]  ma, mb, lim;
      logic [127:0] prod;
      logic         neg;
      neg = (a < 0) ^ (b < 0);
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      prod = (prod + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
      if (prod > {64'd0, lim}) begin
         sat = 1'b1;
         prod = {64'd0, lim};
      end
      return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   endfunction

   function automatic h_result_type clenshaw_h(input logic signed [ccse_pkg::X_WIDTH-1:0] x_in);
      logic signed [63:0] x, x2, z, b0, b1, b2, tz, c, d, h;
      bit                 sat;
      int                 n;
      h_result_type       r;
      sat = 1'b0;
      x = 64'(x_in);
      x2 = round_mul(x, x, 28, sat);
      z = round_mul($signed({16'd0, scale_cfg}), x2, 32, sat);
      z = clamp48(z - $signed({16'd0, offset_cfg}), sat);
      b0 = '0;
      b1 = '0;
      for (n = int'(order_cfg); n >= 0; n--) begin
         b2 = b1;
         b1 = b0;
         tz = round_mul(z, b1, 31, sat);
         c = clamp48(64'(coeff_copy[n]), sat);
         b0 = clamp48(c + tz - b2, sat);
      end
      tz = round_mul(b1, z, 32, sat);
      d = clamp48(b0 - tz, sat);
      tz = round_mul(x, d, 31, sat);
      h = clamp48(HALF_Q32 - tz, sat);
      r.h = h[ccse_pkg::VAL_WIDTH-1:0];
      r.sat = sat;
      return r;
   endfunction

   // Fields that an operation ignores are filled with random values.
   function automatic series_word_type load_word(input int idx,
                                                 input logic signed [ccse_pkg::VAL_WIDTH-1:0] v);
      series_word_type w;
      w.opcode = ccse_pkg::OP_LOAD;
      w.index = ccse_pkg::ORDER_WIDTH'(idx);
      w.coeff = v;
      w.x = $urandom();
      return w;
   endfunction

   function automatic series_word_type eval_word(input logic signed [ccse_pkg::X_WIDTH-1:0] xv);
      series_word_type w;
      w.opcode = ccse_pkg::OP_EVAL;
      w.index = ccse_pkg::ORDER_WIDTH'($urandom());
      w.coeff = ccse_pkg::VAL_WIDTH'({$urandom(), $urandom()});
      w.x = xv;
      return w;
   endfunction

   function automatic logic signed [ccse_pkg::VAL_WIDTH-1:0] random_coeff();
      logic signed [33:0] s;
      case ($urandom_range(0, 15))
         0: return ccse_pkg::VAL_MAX;
         1: return ccse_pkg::VAL_MIN;
         2, 3: return ccse_pkg::VAL_WIDTH'({$urandom(), $urandom()});
         default: begin
            s = 34'({$urandom_range(0, 3), $urandom()});
            return ccse_pkg::VAL_WIDTH'(s);
         end
      endcase
   endfunction

   function automatic logic signed [ccse_pkg::X_WIDTH-1:0] random_x();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   function automatic void push_word(input series_word_type w);
      word_queue.push_back(w);
      words_left++;
   endfunction

   // Driver: bursts of words with random gaps, fed from word_queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (cur_word.opcode == ccse_pkg::OP_LOAD) coeff_copy[cur_word.index] = cur_word.coeff;
            else h_pending.push_back(clenshaw_h(cur_word.x));
            words_left--;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 && !no_idle) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               cur_word = word_queue.pop_front();
               req_opcode <= cur_word.opcode;
               req_coeff_index <= cur_word.index;
               req_coeff_value <= cur_word.coeff;
               req_x_value <= cur_word.x;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 7);
                  gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) :
                             $urandom_range(0, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      h_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (h_pending.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_h_value));
         end else begin
            want = h_pending.pop_front();
            if (rsp_h_value !== want.h)
               report_mismatch($sformatf("h_value %h, expected %h", rsp_h_value, want.h));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("saturated %b, expected %b", rsp_saturated, want.sat));
         end
      end
      if ($urandom_range(0, 99) == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pattern = 16'($urandom() | $urandom());
            1: stall_pattern = 16'($urandom() & $urandom());
            default: stall_pattern = 16'hFFFF;
         endcase
      end else begin
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_ready <= no_idle || stall_pattern[0];
   end

   task automatic wait_idle();
      while (words_left != 0 || h_pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Registers are written one per cycle, starting at a rising edge.
   task automatic program_regs(input logic [ccse_pkg::ORDER_WIDTH-1:0] order,
                               input logic [ccse_pkg::VAL_WIDTH-1:0] scale,
                               input logic [ccse_pkg::VAL_WIDTH-1:0] offset);
      logic [ccse_pkg::VAL_WIDTH-1:0] data;
      data = ccse_pkg::VAL_WIDTH'({$urandom(), $urandom()});
      data[ccse_pkg::ORDER_WIDTH-1:0] = order;
      csr_wr_en <= 1'b1;
      csr_index <= ccse_pkg::CSR_TERM_ORDER;
      csr_wr_data <= data;
      @(posedge clock);
      csr_index <= ccse_pkg::CSR_Z_SCALE;
      csr_wr_data <= scale;
      @(posedge clock);
      csr_index <= ccse_pkg::CSR_Z_OFFSET;
      csr_wr_data <= offset;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_cfg = order;
      scale_cfg = scale;
      offset_cfg = offset;
   endtask

   // Entries below fill_count are loaded first, before the phase's random words.
   task automatic run_phase(input logic [ccse_pkg::ORDER_WIDTH-1:0] order,
                            input logic [ccse_pkg::VAL_WIDTH-1:0] scale,
                            input logic [ccse_pkg::VAL_WIDTH-1:0] offset,
                            input logic calm, input int fill_count, input int n_words);
      int i;
      program_regs(order, scale, offset);
      no_idle <= calm;
      for (i = 0; i < fill_count; i++)
         push_word(load_word(i, $signed(ccse_pkg::VAL_WIDTH'(int'($urandom()) >>> 2))));
      if (fill_count > 0) push_word(eval_word(random_x()));
      for (i = 0; i < n_words; i++) begin
         if ($urandom_range(0, 99) < 55)
            push_word(eval_word(random_x()));
         else if ($urandom_range(0, 3) == 0)
            push_word(load_word(int'($urandom_range(0, ccse_pkg::MAX_TERMS - 1)),
                                random_coeff()));
         else
            push_word(load_word(int'($urandom_range(0, 47)), random_coeff()));
      end
      wait_idle();
   endtask

   initial begin
      logic [ccse_pkg::VAL_WIDTH-1:0] scale, offset;
      int p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset register values, order zero: extremes of x and of the coefficient.
      push_word(load_word(0, 48'sh0001_0000_0000));
      push_word(eval_word(32'sh0000_0000));
      push_word(eval_word(32'sh4000_0000));
      push_word(eval_word(-32'sh4000_0000));
      push_word(eval_word(32'sh2000_0000));
      push_word(load_word(0, ccse_pkg::VAL_MAX));
      push_word(eval_word(32'sh7FFF_FFFF));
      push_word(eval_word(32'sh8000_0000));
      push_word(eval_word(32'sh4000_0000));
      push_word(load_word(0, ccse_pkg::VAL_MIN));
      push_word(eval_word(32'sh4000_0000));
      push_word(eval_word(-32'sh4000_0000));
      push_word(load_word(ccse_pkg::MAX_TERMS - 1, ccse_pkg::VAL_MAX));
      push_word(load_word(0, -48'sh0001_0000_0000));
      push_word(eval_word(32'sh7FFF_FFFF));
      wait_idle();

      run_phase(10'd31, ccse_pkg::Z_SCALE_RESET, ccse_pkg::Z_OFFSET_RESET, 1'b1, 32, 40);
      run_phase(10'd0, '0, '0, 1'b0, 0, 40);
      run_phase(10'd31, {ccse_pkg::VAL_WIDTH{1'b1}}, {ccse_pkg::VAL_WIDTH{1'b1}}, 1'b0, 0, 40);
      // A long series reads every entry up to 255, so those are loaded first.
      run_phase(10'd255, 48'h2_4000_0000, 48'h1_4000_0000, 1'b0, 256, 2);

      for (p = 0; p < 6; p++) begin
         case ($urandom_range(0, 2))
            0: begin
               scale = 48'h2_0000_0000 +
                       ccse_pkg::VAL_WIDTH'({$urandom_range(0, 1), $urandom()});
               offset = scale - 48'h1_0000_0000;
            end
            1: begin
               scale = ccse_pkg::VAL_WIDTH'({$urandom(), $urandom()});
               offset = ccse_pkg::VAL_WIDTH'({$urandom(), $urandom()});
            end
            default: begin
               scale = ccse_pkg::VAL_WIDTH'({$urandom_range(0, 7), $urandom()});
               offset = ccse_pkg::VAL_WIDTH'({$urandom_range(0, 3), $urandom()});
            end
         endcase
         run_phase(ccse_pkg::ORDER_WIDTH'($urandom_range(0, 40)), scale, offset,
                   $urandom_range(0, 3) == 0, 0, 25);
      end

      repeat (50) @(posedge clock);
      if (h_pending.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", h_pending.size()));
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
